// ===== rtl/core/lsdrs_pkg.sv =====
`timescale 1ns / 1ps

package lsdrs_pkg;

  localparam int KEY_W = 64;
  localparam int TAG_W = 16;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } item_t;

endpackage

// ===== rtl/core/lsd_radix_sort_key_tag.sv =====
`timescale 1ns / 1ps

// Batch sorter: key/tag pairs come in on the input channel (in_valid/in_ready),
// one beat per cycle while loading. The beat with last set closes the batch;
// in_ready then drops while the batch is sorted with a stable LSD radix sort
// and the pairs leave on the output channel (out_valid/out_ready) in
// ascending key order, end_of_batch on the final beat, dropped on every beat
// of a batch that overflowed MAX_ITEMS.
// The sort runs P = ceil(64 / DIGIT_BITS) digit passes, B = 2**DIGIT_BITS buckets:
//   each digit pass: histogram clear over the B buckets, count, prefix scan,
//   placement, all through the histogram RAM (one read and one write port).
//   output then issues one registered read of the item RAM at a time and waits
//   for it to reach the output register before it issues the next.
// Items ping-pong between two banks of the item RAM, one bank per pass.
// in_ready returns once the last result read is issued, so loading the next
// batch overlaps the final beat waiting in the output register.
// A receiver stall holds the output register and pauses the reads behind it.
// Reset (rst, synchronous) empties the batch and the output register; RAM
// contents are not cleared, the histogram is swept clear at each pass.
module lsd_radix_sort_key_tag
  import lsdrs_pkg::*;
#(
  parameter int MAX_ITEMS  = 64,
  parameter int DIGIT_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [KEY_W-1:0] key,
  input  logic [TAG_W-1:0] tag,
  input  logic             last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KEY_W-1:0] sorted_key,
  output logic [TAG_W-1:0] sorted_tag,
  output logic             end_of_batch,
  output logic             dropped
);

  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int IW      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int BUCKETS = 1 << DIGIT_BITS;
  localparam int PASSES  = (KEY_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PW      = $clog2(PASSES + 1);
  localparam int SH_W    = $clog2(KEY_W + 1);

  localparam logic [CNT_W-1:0]    MAX_N     = CNT_W'(MAX_ITEMS);
  localparam logic [DIGIT_BITS:0] BKT_END   = (DIGIT_BITS + 1)'(BUCKETS);
  localparam logic [DIGIT_BITS:0] BKT_LAST  = (DIGIT_BITS + 1)'(BUCKETS - 1);
  localparam logic [PW-1:0]       PASS_LAST = PW'(PASSES - 1);
  localparam logic [SH_W-1:0]     SH_STEP   = SH_W'(DIGIT_BITS);
  localparam logic                FIN_BANK  = 1'(PASSES % 2);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_COUNT = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // storage
  item_t            store_mem [0:1][0:MAX_ITEMS-1];
  logic [CNT_W-1:0] hist_mem  [0:BUCKETS-1];
  item_t            store_rd;
  logic [CNT_W-1:0] hist_rd;

  // control
  logic [2:0]          state;
  logic [CNT_W-1:0]    fill;
  logic                ovf;
  logic [CNT_W-1:0]    sort_n;
  logic                sort_drop;
  logic [PW-1:0]       pass;
  logic [SH_W-1:0]     shamt;
  logic [CNT_W-1:0]    idx;
  logic [DIGIT_BITS:0] bkt;
  logic [CNT_W-1:0]    acc;
  logic                v1;
  logic                v2;
  logic                sv;
  logic                fwd_v;
  logic                pend;
  logic                pend_last;

  // pipeline payload
  logic [DIGIT_BITS-1:0] d2;
  item_t                 item2;
  logic [DIGIT_BITS-1:0] sa;
  logic [DIGIT_BITS-1:0] fwd_a;
  logic [CNT_W-1:0]      fwd_d;

  logic                  walk;
  logic                  src;
  logic                  in_acc;
  logic                  stored;
  logic                  w_issue;
  logic                  w_done;
  logic                  s_issue;
  logic                  s_done;
  logic                  o_issue;
  logic [KEY_W-1:0]      key_sh;
  logic [DIGIT_BITS-1:0] digit1;
  logic [CNT_W-1:0]      cur;
  logic [CNT_W-1:0]      cur_inc;

  logic                  st_rbank;
  logic                  st_we;
  logic                  st_wbank;
  logic [IW-1:0]         st_widx;
  item_t                 st_wdata;
  logic [DIGIT_BITS-1:0] h_raddr;
  logic                  h_we;
  logic [DIGIT_BITS-1:0] h_waddr;
  logic [CNT_W-1:0]      h_wdata;

  assign in_ready = (state == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign stored   = (fill != MAX_N);
  assign walk     = (state == S_COUNT) || (state == S_PLACE);
  assign src      = pass[0];

  assign w_issue = walk && (idx != sort_n);
  assign w_done  = (idx == sort_n) && !v1 && !v2;
  assign s_issue = (state == S_SCAN) && (bkt != BKT_END);
  assign s_done  = (bkt == BKT_END) && !sv;
  assign o_issue = (state == S_OUT) && !pend && (!out_valid || out_ready);

  assign key_sh  = store_rd.key >> shamt;
  assign digit1  = key_sh[DIGIT_BITS-1:0];
  // the previous cycle's write has not reached the registered read yet
  assign cur     = (fwd_v && (fwd_a == d2)) ? fwd_d : hist_rd;
  assign cur_inc = cur + 1'b1;

  always_comb begin
    st_rbank = (state == S_OUT) ? FIN_BANK : src;
    st_we    = (in_acc && stored) || ((state == S_PLACE) && v2);
    st_wbank = in_acc ? 1'b0 : ~src;
    st_widx  = in_acc ? fill[IW-1:0] : cur[IW-1:0];
    st_wdata = in_acc ? item_t'{key: key, tag: tag} : item2;

    h_raddr = (state == S_SCAN) ? bkt[DIGIT_BITS-1:0] : digit1;
    h_we    = 1'b0;
    h_waddr = d2;
    h_wdata = cur_inc;
    case (state)
      S_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = bkt[DIGIT_BITS-1:0];
        h_wdata = '0;
      end
      S_SCAN: begin
        h_we    = sv;
        h_waddr = sa;
        h_wdata = acc;
      end
      S_COUNT, S_PLACE: begin
        h_we = v2;
      end
      default: begin
        h_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wbank][st_widx] <= st_wdata;
    end
    store_rd <= store_mem[st_rbank][idx[IW-1:0]];
    if (h_we) begin
      hist_mem[h_waddr] <= h_wdata;
    end
    hist_rd <= hist_mem[h_raddr];
  end

  // pipeline payload, no reset
  always_ff @(posedge clk) begin
    d2    <= digit1;
    item2 <= store_rd;
    sa    <= bkt[DIGIT_BITS-1:0];
    fwd_a <= d2;
    fwd_d <= cur_inc;
    if (s_issue) begin
      acc <= acc;
    end
    if (sv) begin
      acc <= acc + hist_rd;
    end
    if (state == S_COUNT && w_done) begin
      acc <= '0;
    end
    if (in_acc && last) begin
      sort_n    <= fill + CNT_W'(stored);
      sort_drop <= ovf || !stored;
    end
    if (o_issue) begin
      pend_last <= (idx == sort_n - 1'b1);
    end
    if (pend) begin
      sorted_key   <= store_rd.key;
      sorted_tag   <= store_rd.tag;
      end_of_batch <= pend_last;
      dropped      <= sort_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      fill      <= '0;
      ovf       <= 1'b0;
      pass      <= '0;
      shamt     <= '0;
      idx       <= '0;
      bkt       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      sv        <= 1'b0;
      fwd_v     <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1    <= w_issue;
      v2    <= walk && v1;
      sv    <= s_issue;
      fwd_v <= walk && v2;
      pend  <= o_issue;

      if (pend) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (stored) begin
              fill <= fill + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (last) begin
              fill  <= '0;
              ovf   <= 1'b0;
              pass  <= '0;
              shamt <= '0;
              bkt   <= '0;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (bkt == BKT_LAST) begin
            bkt   <= '0;
            idx   <= '0;
            state <= S_COUNT;
          end else begin
            bkt <= bkt + 1'b1;
          end
        end
        S_COUNT: begin
          if (w_issue) begin
            idx <= idx + 1'b1;
          end
          if (w_done) begin
            bkt   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (s_issue) begin
            bkt <= bkt + 1'b1;
          end
          if (s_done) begin
            idx   <= '0;
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (w_issue) begin
            idx <= idx + 1'b1;
          end
          if (w_done) begin
            bkt <= '0;
            idx <= '0;
            if (pass == PASS_LAST) begin
              state <= S_OUT;
            end else begin
              pass  <= pass + 1'b1;
              shamt <= shamt + SH_STEP;
              state <= S_CLEAR;
            end
          end
        end
        S_OUT: begin
          if (o_issue) begin
            idx <= idx + 1'b1;
            if (idx == sort_n - 1'b1) begin
              idx   <= '0;
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a result only reaches the output register from a completed RAM read
  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pend))
    else $error("out_valid rose without a pending read");

  // placement positions stay inside the batch
  a_place_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PLACE) && v2) |-> (cur < sort_n))
    else $error("placement position beyond batch size");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= MAX_N)
    else $error("fill count beyond capacity");

  // a new read is never issued while one is still in flight
  a_one_read: assert property (@(posedge clk) disable iff (rst)
    pend |-> !o_issue)
    else $error("overlapping output reads");
`endif

endmodule
